// ----- hw/rtl/pts_pkg.sv -----
// Shared constants, types and codes for the patch table search block.
package pts_pkg;

  // Table geometry
  localparam int TABLE_DEPTH   = 64;
  localparam int IDX_W         = $clog2(TABLE_DEPTH);
  localparam int BND_W         = IDX_W + 1;
  localparam int ENTRY_INDEX_W = 6;
  localparam int KEY_W         = 32;
  localparam int ADDR_W        = 32;

  // First probe of every search: midpoint of the full table
  localparam int MID_FIRST = (TABLE_DEPTH - 1) / 2;

  // Miss address after reset
  localparam logic [ADDR_W-1:0] MISS_RESET = 32'h2000_9001;

  // Command codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // Table read request
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } rd_req_t;

  // Table write request
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [KEY_W-1:0]  key;
    logic [ADDR_W-1:0] value;
  } wr_req_t;

  // Registered table read data
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [ADDR_W-1:0] value;
  } rd_data_t;

endpackage

// ----- hw/rtl/pts_table.sv -----
// Key/value table: two synchronous memories with per-entry valid bits.
module pts_table (
  input  logic               clk,
  input  logic               rst,
  input  pts_pkg::wr_req_t   wr_req,
  input  pts_pkg::rd_req_t   rd_req,
  output pts_pkg::rd_data_t  rd_data
);

  logic [pts_pkg::KEY_W-1:0]  key_mem   [pts_pkg::TABLE_DEPTH];
  logic [pts_pkg::ADDR_W-1:0] value_mem [pts_pkg::TABLE_DEPTH];
  logic [pts_pkg::TABLE_DEPTH-1:0] entry_valid;

  logic [pts_pkg::KEY_W-1:0]  rd_key;
  logic [pts_pkg::ADDR_W-1:0] rd_value;
  logic                       rd_valid;

  // Memory write port
  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      key_mem[wr_req.addr]   <= wr_req.key;
      value_mem[wr_req.addr] <= wr_req.value;
    end
  end

  // Memory read port, registered
  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      rd_key   <= key_mem[rd_req.addr];
      rd_value <= value_mem[rd_req.addr];
    end
  end

  // Valid bits: an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_valid    <= 1'b0;
    end else begin
      if (wr_req.en) begin
        entry_valid[wr_req.addr] <= 1'b1;
      end
      if (rd_req.en) begin
        rd_valid <= entry_valid[rd_req.addr];
      end
    end
  end

  assign rd_data.key   = rd_valid ? rd_key   : '0;
  assign rd_data.value = rd_valid ? rd_value : '0;

endmodule

// ----- hw/rtl/pts_search.sv -----
// Binary search sequencer: probes the table one entry per cycle.
module pts_search (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        search_start,
  input  logic [pts_pkg::KEY_W-1:0]   search_key,
  input  logic [pts_pkg::ADDR_W-1:0]  miss_address,
  input  pts_pkg::rd_data_t           rd_data,
  output pts_pkg::rd_req_t            rd_req,
  output logic                        busy,
  output logic                        result_valid,
  output logic [pts_pkg::ADDR_W-1:0]  result_address,
  output logic                        found
);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_PROBE = 1'b1;

  logic                        state, state_next;
  logic [pts_pkg::BND_W-1:0]   lo, lo_next;
  logic [pts_pkg::BND_W-1:0]   hi_ex, hi_ex_next;   // upper bound plus one
  logic [pts_pkg::IDX_W-1:0]   mid, mid_next;
  logic [pts_pkg::KEY_W-1:0]   skey;
  logic                        result_valid_next;
  logic [pts_pkg::ADDR_W-1:0]  result_address_next;
  logic                        found_next;
  logic                        rd_en;

  logic                        key_gt, key_lt;
  logic [pts_pkg::BND_W-1:0]   mid_ext;
  logic [pts_pkg::BND_W-1:0]   span;

  assign mid_ext = pts_pkg::BND_W'(mid);
  assign key_gt  = rd_data.key > skey;
  assign key_lt  = rd_data.key < skey;

  // Bound update, next probe and result on hit or miss
  always_comb begin
    state_next          = state;
    lo_next             = lo;
    hi_ex_next          = hi_ex;
    mid_next            = mid;
    result_valid_next   = 1'b0;
    result_address_next = result_address;
    found_next          = found;
    rd_en               = 1'b0;
    span                = '0;
    case (state)
      S_IDLE: begin
        if (search_start) begin
          lo_next    = '0;
          hi_ex_next = pts_pkg::BND_W'(pts_pkg::TABLE_DEPTH);
          mid_next   = pts_pkg::IDX_W'(pts_pkg::MID_FIRST);
          rd_en      = 1'b1;
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (!key_gt && !key_lt) begin
          // hit
          result_valid_next   = 1'b1;
          result_address_next = rd_data.value;
          found_next          = 1'b1;
          state_next          = S_IDLE;
        end else begin
          if (key_gt) begin
            lo_next = mid_ext + 1'b1;
          end else begin
            hi_ex_next = mid_ext;
          end
          span     = hi_ex_next - lo_next - 1'b1;
          mid_next = pts_pkg::IDX_W'(lo_next + (span >> 1));
          if (lo_next < hi_ex_next) begin
            rd_en = 1'b1;
          end else begin
            // range empty: miss
            result_valid_next   = 1'b1;
            result_address_next = miss_address;
            found_next          = 1'b0;
            state_next          = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign rd_req.en   = rd_en;
  assign rd_req.addr = mid_next;
  assign busy        = (state != S_IDLE);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  // Search and result payload
  always_ff @(posedge clk) begin
    lo             <= lo_next;
    hi_ex          <= hi_ex_next;
    mid            <= mid_next;
    result_address <= result_address_next;
    found          <= found_next;
    if (search_start && state == S_IDLE) begin
      skey <= search_key;
    end
  end

  // A probe only happens after a read was issued
  a_probe_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) |-> $past(rd_req.en))
    else $error("probe state without a table read");

  // The probed entry lies inside the current bounds
  a_mid_in_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) |-> ((lo <= mid_ext) && (mid_ext < hi_ex)))
    else $error("probe address outside search bounds");

  // A result follows a search in progress
  a_result_from_search: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(state) == S_PROBE))
    else $error("result without a search");

  // One result per search, never on consecutive cycles
  a_result_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held for more than one cycle");

endmodule

// ----- hw/rtl/patch_table_binary_search.sv -----
// Top level of the patch table search block: command port, miss register, table and search.
//
// Usage:
//   An item is taken at a rising edge with start high and busy low. command selects
//   a table write (entry_index, entry_key, entry_value) or a search (search_key).
//   A write completes at that edge, raises no busy and gives no result; a write to
//   an index beyond the table is dropped.
//   A search raises busy and walks the table by binary search, one probe per cycle:
//   each probe is a read of the key/value memories, whose registered data is
//   compared the following cycle while the next probe address is issued.
//   The result (result_address, found) is shown for exactly one cycle with
//   result_valid high, after at most log2(depth)+1 probes; busy drops with
//   it, so the next item can be taken in the cycle the result is shown.
//   The receiver cannot stall; each result is taken in its strobe cycle.
//   The user must write miss_address through cfg_valid/cfg_ready/cfg_data
//   only while idle; the block itself does not enforce this.
//   Reset clears every table entry to zero through per-entry valid bits, so the
//   block takes items right after reset, and loads miss_address with 0x20009001.
module patch_table_binary_search (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [5:0]  entry_index,
  input  logic [31:0] entry_key,
  input  logic [31:0] entry_value,
  input  logic [31:0] search_key,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output logic        result_valid,
  output logic [31:0] result_address,
  output logic        found
);

  logic                        accept;
  logic                        search_start;
  logic [pts_pkg::ADDR_W-1:0]  miss_address;
  pts_pkg::wr_req_t            wr_req;
  pts_pkg::rd_req_t            rd_req;
  pts_pkg::rd_data_t           rd_data;

  assign accept       = start && !busy;
  assign search_start = accept && (command == pts_pkg::CMD_SEARCH);

  // Table write on a write command inside the table
  assign wr_req.en    = accept && (command == pts_pkg::CMD_WRITE) &&
                        (32'(entry_index) < 32'(pts_pkg::TABLE_DEPTH));
  assign wr_req.addr  = pts_pkg::IDX_W'(entry_index);
  assign wr_req.key   = entry_key;
  assign wr_req.value = entry_value;

  // Miss address register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      miss_address <= pts_pkg::MISS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      miss_address <= cfg_data;
    end
  end

  pts_table u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_req  (wr_req),
    .rd_req  (rd_req),
    .rd_data (rd_data)
  );

  pts_search u_search (
    .clk            (clk),
    .rst            (rst),
    .search_start   (search_start),
    .search_key     (search_key),
    .miss_address   (miss_address),
    .rd_data        (rd_data),
    .rd_req         (rd_req),
    .busy           (busy),
    .result_valid   (result_valid),
    .result_address (result_address),
    .found          (found)
  );

endmodule

// ----- bench/tb_top.sv -----
// Testbench for the patch table search block: directed and random lookups vs a shadow table.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 10;
  localparam int PHASE_ITEMS = 320;

  // Expected outcome of one lookup
  typedef struct packed {
    logic [pts_pkg::ADDR_W-1:0] address;
    logic                       found;
  } lookup_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        command = pts_pkg::CMD_WRITE;
  logic [5:0]  entry_index = '0;
  logic [31:0] entry_key = '0;
  logic [31:0] entry_value = '0;
  logic [31:0] search_key = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  logic        result_valid;
  logic [31:0] result_address;
  logic        found;

  // Shadow copy of the table and the miss register
  logic [pts_pkg::KEY_W-1:0]  key_shadow [pts_pkg::TABLE_DEPTH];
  logic [pts_pkg::ADDR_W-1:0] value_shadow [pts_pkg::TABLE_DEPTH];
  logic [pts_pkg::ADDR_W-1:0] miss_shadow;

  lookup_result_t pending_lookups [$];
  bit failed = 1'b0;
  int gap_pct = 0;
  int idle_cycles = 0;

  patch_table_binary_search dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .entry_index   (entry_index),
    .entry_key     (entry_key),
    .entry_value   (entry_value),
    .search_key    (search_key),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .result_valid  (result_valid),
    .result_address(result_address),
    .found         (found)
  );

  always #1 clk = ~clk;

  // Binary search over the shadow table, same probe order as the hardware
  function automatic lookup_result_t predict_lookup(logic [pts_pkg::KEY_W-1:0] key);
    lookup_result_t r;
    int lo;
    int hi;
    int mid;
    r.address = miss_shadow;
    r.found = 1'b0;
    lo = 0;
    hi = pts_pkg::TABLE_DEPTH - 1;
    while (lo <= hi && !r.found) begin
      mid = lo + (hi - lo) / 2;
      if (key_shadow[mid] > key) begin
        lo = mid + 1;
      end else if (key_shadow[mid] < key) begin
        hi = mid - 1;
      end else begin
        r.address = value_shadow[mid];
        r.found = 1'b1;
      end
    end
    return r;
  endfunction

  // One item transfer; start is left high so back-to-back items need no toggle
  task automatic send_item(input logic cmd, input logic [5:0] idx,
                           input logic [31:0] wkey, input logic [31:0] wval,
                           input logic [31:0] skey);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    start       <= 1'b1;
    command     <= cmd;
    entry_index <= idx;
    entry_key   <= wkey;
    entry_value <= wval;
    search_key  <= skey;
    do @(posedge clk); while (busy);
    // accepted at this edge
    if (cmd == pts_pkg::CMD_WRITE) begin
      if (idx < pts_pkg::TABLE_DEPTH) begin
        key_shadow[idx]   = wkey;
        value_shadow[idx] = wval;
      end
    end else begin
      pending_lookups.push_back(predict_lookup(skey));
    end
  endtask

  task automatic put_entry(input logic [5:0] idx, input logic [31:0] key,
                           input logic [31:0] value);
    send_item(pts_pkg::CMD_WRITE, idx, key, value, $urandom);
  endtask

  task automatic lookup(input logic [31:0] key);
    send_item(pts_pkg::CMD_SEARCH, 6'($urandom), $urandom, $urandom, key);
  endtask

  // Stop issuing and wait until every lookup has answered
  task automatic settle();
    start <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Miss register write, only from an idle block
  task automatic write_miss(input logic [31:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    miss_shadow = value;
  endtask

  // Fill the whole table with descending keys at a random spread
  task automatic load_sorted_table();
    logic [31:0] cur;
    logic [31:0] step_max;
    logic [31:0] dec;
    int mode;
    mode = $urandom_range(2);
    step_max = (mode == 0) ? 32'd1 : (mode == 1) ? 32'd1024 : 32'h0400_0000;
    cur = $urandom_range(1) ? 32'hFFFF_FFFF : $urandom;
    for (int i = 0; i < pts_pkg::TABLE_DEPTH; i++) begin
      put_entry(6'(i), cur, $urandom);
      dec = $urandom_range(step_max);
      cur = (dec > cur) ? 32'd0 : cur - dec;
    end
  endtask

  // Lookup key biased toward stored keys and their neighbors
  function automatic logic [31:0] pick_search_key();
    logic [31:0] k;
    int r;
    k = key_shadow[$urandom_range(pts_pkg::TABLE_DEPTH - 1)];
    r = $urandom_range(99);
    if (r < 55) return k;
    if (r < 70) return k + 32'd1;
    if (r < 85) return k - 32'd1;
    if (r < 95) return $urandom;
    return $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
  endfunction

  // Cleared table: key zero hits the first probe, anything else misses
  task automatic test_reset_state();
    lookup(32'd0);
    lookup(32'd1);
    lookup(32'hFFFF_FFFF);
  endtask

  // Hits at both ends of the table and a miss between stored keys
  task automatic test_table_ends();
    put_entry(6'd0, 32'hFFFF_FFFF, 32'hAAAA_5555);
    put_entry(6'd31, 32'd100, 32'h1234_5678);
    put_entry(6'd47, 32'd50, 32'h0000_0000);
    put_entry(6'd55, 32'd25, 32'h5555_AAAA);
    put_entry(6'd59, 32'd12, 32'h0F0F_0F0F);
    put_entry(6'd61, 32'd6, 32'hF0F0_F0F0);
    put_entry(6'd62, 32'd3, 32'h8000_0001);
    put_entry(6'd63, 32'd0, 32'hFFFF_FFFF);
    lookup(32'd0);
    lookup(32'hFFFF_FFFF);
    lookup(32'd100);
    lookup(32'd51);
  endtask

  // Key stored off the probe path is missed
  task automatic test_unsorted();
    put_entry(6'd40, 32'd7, 32'hDEAD_BEEF);
    lookup(32'd7);
  endtask

  // Miss register at both extremes
  task automatic test_miss_register();
    write_miss(32'd0);
    lookup(32'd999);
    write_miss(32'hFFFF_FFFF);
    lookup(32'd999);
  endtask

  // Sorted tables with random lookups, some stray writes and pauses
  task automatic test_random_phase(input int idle_pct, input logic [31:0] miss_value);
    int sent;
    int r;
    write_miss(miss_value);
    gap_pct = idle_pct;
    load_sorted_table();
    sent = pts_pkg::TABLE_DEPTH;
    while (sent < PHASE_ITEMS) begin
      r = $urandom_range(99);
      if (r < 1) begin
        load_sorted_table();
        sent += pts_pkg::TABLE_DEPTH;
      end else if (r < 9) begin
        put_entry(6'($urandom), $urandom, $urandom);
        sent++;
      end else if (r < 11) begin
        settle();
      end else begin
        lookup(pick_search_key());
        sent++;
      end
    end
  endtask

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    lookup_result_t exp_r;
    if (!rst && result_valid === 1'b1) begin
      if (pending_lookups.size() == 0) begin
        $display("%0t: unexpected result address %h found %b", $time,
                 result_address, found);
        failed = 1'b1;
      end else begin
        exp_r = pending_lookups.pop_front();
        if (result_address !== exp_r.address) begin
          $display("%0t: result_address expected %h actual %h", $time,
                   exp_r.address, result_address);
          failed = 1'b1;
        end
        if (found !== exp_r.found) begin
          $display("%0t: found expected %b actual %b", $time, exp_r.found, found);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog on cycles with no transfer of any kind
  always @(posedge clk) begin
    if ((start && !busy) || result_valid === 1'b1 || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < pts_pkg::TABLE_DEPTH; i++) begin
      key_shadow[i] = '0;
      value_shadow[i] = '0;
    end
    miss_shadow = pts_pkg::MISS_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    gap_pct = 13;
    test_reset_state();
    test_table_ends();
    test_unsorted();
    test_miss_register();

    test_random_phase(13, $urandom);
    test_random_phase(45, $urandom);
    test_random_phase(0, pts_pkg::MISS_RESET);

    settle();
    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
